// File: src/gn3_pkg.sv
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants, tables and helper functions for the 3D gradient noise
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gn3_pkg;

	// Default number of fraction bits in a coordinate.
	localparam int FRAC_BITS_DEF = 16;

	// Coordinate and result widths.
	localparam int COORD_W = 32;
	localparam int NOISE_W = 16;

	// Internal fraction is unsigned Q0.16.
	localparam int IQ = 16;

	// Width of an interpolated value (signed Q.16) and of a corner dot product.
	localparam int VAL_W = 24;
	localparam int DOT_W = 19;

	// Fade polynomial coefficients.
	localparam int FADE_A = 6;
	localparam int FADE_B = 15;
	localparam int FADE_C = 10;

	// Gradient count.
	localparam int GRAD_COUNT = 12;

	// Fixed permutation table.
	localparam logic [7:0] PERM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
		8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
		8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
		8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
		8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
		8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
		8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
		8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
		8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
		8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
		8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
		8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
		8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
		8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
		8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
		8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
		8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
		8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
		8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
		8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
		8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
		8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
		8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
		8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
		8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
		8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
		8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
		8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
	};

	// Gradient index: hash mod 12, by a reciprocal multiply and one correction.
	function automatic logic [3:0] grad_index(input logic [7:0] h);
		logic [15:0] prod;
		logic [4:0]  quo;
		logic [8:0]  rem;
		prod = 16'(h) * 16'd171;
		quo  = prod[15:11];
		rem  = 9'(h) - 9'(quo) * 9'(GRAD_COUNT);
		if (rem >= 9'(GRAD_COUNT)) begin
			rem = rem - 9'(GRAD_COUNT);
		end
		return rem[3:0];
	endfunction

	// Dot product of one of the GRAD_COUNT edge gradients with a corner offset.
	function automatic logic signed [DOT_W-1:0] grad_dot(
		input logic [3:0]         gi,
		input logic signed [16:0] dx,
		input logic signed [16:0] dy,
		input logic signed [16:0] dz
	);
		logic signed [DOT_W-1:0] x;
		logic signed [DOT_W-1:0] y;
		logic signed [DOT_W-1:0] z;
		logic signed [DOT_W-1:0] d;
		x = DOT_W'(dx);
		y = DOT_W'(dy);
		z = DOT_W'(dz);
		case (gi)
			4'd0:    d =  x + y;
			4'd1:    d = -x + y;
			4'd2:    d =  x - y;
			4'd3:    d = -x - y;
			4'd4:    d =  x + z;
			4'd5:    d = -x + z;
			4'd6:    d =  x - z;
			4'd7:    d = -x - z;
			4'd8:    d =  y + z;
			4'd9:    d = -y + z;
			4'd10:   d =  y - z;
			4'd11:   d = -y - z;
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// File: src/gn3_in_if.sv
// ----------------------------------------------------------------------------
// gn3_in_if
// Input channel: one 3D point per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gn3_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [gn3_pkg::COORD_W-1:0] coord_x;
	logic signed [gn3_pkg::COORD_W-1:0] coord_y;
	logic signed [gn3_pkg::COORD_W-1:0] coord_z;

	modport source (output valid, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

`default_nettype wire

// File: src/gn3_out_if.sv
// ----------------------------------------------------------------------------
// gn3_out_if
// Output channel: one noise value per word, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gn3_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [gn3_pkg::NOISE_W-1:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

`default_nettype wire

// File: src/gn3_fade.sv
// ----------------------------------------------------------------------------
// gn3_fade
// Pipelined quintic fade 6t^5 - 15t^4 + 10t^3 in Horner form, one multiply
// per stage, rounding half up after each product.
// ----------------------------------------------------------------------------
`default_nettype none

module gn3_fade (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [15:0]         frac,
	output logic signed [17:0]       fade
);

	localparam int R_W = 22;
	localparam int P_W = 40;

	// Round a Q.32 product back to Q.16, half up.
	function automatic logic signed [R_W-1:0] rnd(input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] s;
		s = (p + P_W'(32'sd32768)) >>> gn3_pkg::IQ;
		return s[R_W-1:0];
	endfunction

	logic signed [17:0]    t_s1;
	logic signed [R_W-1:0] r0;
	logic signed [R_W-1:0] r1;
	logic signed [R_W-1:0] r2;
	logic signed [R_W-1:0] r3;
	logic signed [R_W-1:0] r4;
	logic signed [17:0]    t_s2;
	logic signed [17:0]    t_s3;
	logic signed [17:0]    t_s4;
	logic signed [P_W-1:0] p_s2;
	logic signed [P_W-1:0] p_s3;
	logic signed [P_W-1:0] p_s4;
	logic signed [P_W-1:0] p_s5;

	// Horner steps between the product registers.
	always_comb begin
		t_s1 = $signed({2'b00, frac});
		r0 = R_W'(t_s1) * R_W'(gn3_pkg::FADE_A)
			- R_W'(gn3_pkg::FADE_B) * (R_W'(1) <<< gn3_pkg::IQ);
		r1 = rnd(p_s2) + R_W'(gn3_pkg::FADE_C) * (R_W'(1) <<< gn3_pkg::IQ);
		r2 = rnd(p_s3);
		r3 = rnd(p_s4);
		r4 = rnd(p_s5);
		fade = r4[17:0];
	end

	// Product registers, one multiply each.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= P_W'(t_s1) * P_W'(r0);
			t_s2 <= t_s1;
			p_s3 <= P_W'(t_s2) * P_W'(r1);
			t_s3 <= t_s2;
			p_s4 <= P_W'(t_s3) * P_W'(r2);
			t_s4 <= t_s3;
			p_s5 <= P_W'(t_s4) * P_W'(r3);
		end
	end

endmodule

`default_nettype wire

// File: src/gradient_noise_3d_top.sv
// An accepted point passes stage registers s1 to s8, then the output register.
// Throughput: one point per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken.
// Reset: arst_n clears the stage valid bits and the output valid; no
// payload register is reset.
// ----------------------------------------------------------------------------
// gradient_noise_3d_top
// Classic 3D gradient noise from a signed fixed point point to signed Q1.15.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_3d_top #(
	parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	gn3_in_if.sink     coord,
	gn3_out_if.source  result
);

	localparam int VW  = gn3_pkg::VAL_W;
	localparam int DW  = gn3_pkg::DOT_W;
	localparam int LPW = VW + 18;

	// Round a lerp product back to Q.16, half up.
	function automatic logic signed [VW-1:0] rnd(input logic signed [LPW-1:0] p);
		logic signed [LPW-1:0] s;
		s = (p + LPW'(32'sd32768)) >>> gn3_pkg::IQ;
		return s[VW-1:0];
	endfunction

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_q;

	// Split of each coordinate into cell and fraction.
	logic [7:0]  cx, cy, cz;
	logic [15:0] fx, fy, fz;

	assign cx = coord.coord_x[FRAC_BITS +: 8];
	assign cy = coord.coord_y[FRAC_BITS +: 8];
	assign cz = coord.coord_z[FRAC_BITS +: 8];

	generate
		if (FRAC_BITS >= gn3_pkg::IQ) begin : g_trunc
			assign fx = coord.coord_x[FRAC_BITS-1 -: 16];
			assign fy = coord.coord_y[FRAC_BITS-1 -: 16];
			assign fz = coord.coord_z[FRAC_BITS-1 -: 16];
		end else begin : g_pad
			assign fx = {coord.coord_x[FRAC_BITS-1:0], {(gn3_pkg::IQ-FRAC_BITS){1'b0}}};
			assign fy = {coord.coord_y[FRAC_BITS-1:0], {(gn3_pkg::IQ-FRAC_BITS){1'b0}}};
			assign fz = {coord.coord_z[FRAC_BITS-1:0], {(gn3_pkg::IQ-FRAC_BITS){1'b0}}};
		end
	endgenerate

	// The pipeline moves when the output register is free or being taken.
	assign en = !valid_q || result.ready;
	assign coord.ready = en;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= coord.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_q  <= valid_s8;
		end
	end

	// Stage 1 registers: cells and fractions.
	logic [7:0]  cx_s1, cy_s1, cz_s1;
	logic [15:0] fx_s1, fy_s1, fz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= cx;
			cy_s1 <= cy;
			cz_s1 <= cz;
			fx_s1 <= fx;
			fy_s1 <= fy;
			fz_s1 <= fz;
		end
	end

	// Fade of each fraction; results appear alongside stage 5.
	logic signed [17:0] fu, fv, fw;

	gn3_fade u_fade_x (.clk(clk), .en(en), .frac(fx_s1), .fade(fu));
	gn3_fade u_fade_y (.clk(clk), .en(en), .frac(fy_s1), .fade(fv));
	gn3_fade u_fade_z (.clk(clk), .en(en), .frac(fz_s1), .fade(fw));

	// Hash pipeline: z lookups, then y, then x and the gradient index.
	logic [7:0]  hz_s2 [2];
	logic [7:0]  hy_s3 [2][2];
	logic [3:0]  gi_s4 [2][2][2];
	logic [7:0]  cx_s2, cy_s2, cx_s3;
	logic [15:0] fx_s2, fy_s2, fz_s2;
	logic [15:0] fx_s3, fy_s3, fz_s3;
	logic [15:0] fx_s4, fy_s4, fz_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				hz_s2[k] <= gn3_pkg::PERM[cz_s1 + 8'(k)];
			end
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			fz_s2 <= fz_s1;

			for (int j = 0; j < 2; j++) begin
				for (int k = 0; k < 2; k++) begin
					hy_s3[j][k] <= gn3_pkg::PERM[cy_s2 + 8'(j) + hz_s2[k]];
				end
			end
			cx_s3 <= cx_s2;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fz_s3 <= fz_s2;

			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					for (int k = 0; k < 2; k++) begin
						gi_s4[i][j][k] <= gn3_pkg::grad_index(
							gn3_pkg::PERM[cx_s3 + 8'(i) + hy_s3[j][k]]);
					end
				end
			end
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
			fz_s4 <= fz_s3;
		end
	end

	// Corner offsets: the fraction, and the fraction minus one.
	logic signed [16:0] ox [2];
	logic signed [16:0] oy [2];
	logic signed [16:0] oz [2];

	always_comb begin
		ox[0] = $signed({1'b0, fx_s4});
		ox[1] = $signed({1'b1, fx_s4});
		oy[0] = $signed({1'b0, fy_s4});
		oy[1] = $signed({1'b1, fy_s4});
		oz[0] = $signed({1'b0, fz_s4});
		oz[1] = $signed({1'b1, fz_s4});
	end

	// Stage 5: the eight corner dot products.
	logic signed [DW-1:0] n_s5 [2][2][2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					for (int k = 0; k < 2; k++) begin
						n_s5[i][j][k] <= gn3_pkg::grad_dot(gi_s4[i][j][k],
							ox[i], oy[j], oz[k]);
					end
				end
			end
		end
	end

	// Stage 6: interpolation products along x.
	logic signed [LPW-1:0] px_s6 [2][2];
	logic signed [VW-1:0]  ax_s6 [2][2];
	logic signed [17:0]    fv_s6, fw_s6, fw_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 2; j++) begin
				for (int k = 0; k < 2; k++) begin
					px_s6[j][k] <= LPW'(VW'(n_s5[1][j][k]) - VW'(n_s5[0][j][k])) * LPW'(fu);
					ax_s6[j][k] <= VW'(n_s5[0][j][k]);
				end
			end
			fv_s6 <= fv;
			fw_s6 <= fw;
		end
	end

	// Finished x interpolants.
	logic signed [VW-1:0] a [2][2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			for (int k = 0; k < 2; k++) begin
				a[j][k] = ax_s6[j][k] + rnd(px_s6[j][k]);
			end
		end
	end

	// Stage 7: interpolation products along y.
	logic signed [LPW-1:0] py_s7 [2];
	logic signed [VW-1:0]  ay_s7 [2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 2; k++) begin
				py_s7[k] <= LPW'(a[1][k] - a[0][k]) * LPW'(fv_s6);
				ay_s7[k] <= a[0][k];
			end
			fw_s7 <= fw_s6;
		end
	end

	// Finished y interpolants.
	logic signed [VW-1:0] b [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			b[k] = ay_s7[k] + rnd(py_s7[k]);
		end
	end

	// Stage 8: interpolation product along z.
	logic signed [LPW-1:0] pz_s8;
	logic signed [VW-1:0]  az_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			pz_s8 <= LPW'(b[1] - b[0]) * LPW'(fw_s7);
			az_s8 <= b[0];
		end
	end

	// Final value, rounded to Q1.15 and saturated.
	logic signed [VW-1:0] r;
	logic signed [VW-1:0] rh;
	logic signed [gn3_pkg::NOISE_W-1:0] sat;
	logic signed [gn3_pkg::NOISE_W-1:0] noise_q;

	always_comb begin
		r  = az_s8 + rnd(pz_s8);
		rh = (r + VW'(1)) >>> 1;
		if (rh > VW'(32767)) begin
			sat = 16'sh7fff;
		end else if (rh < -VW'(32768)) begin
			sat = 16'sh8000;
		end else begin
			sat = rh[gn3_pkg::NOISE_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (en) begin
			noise_q <= sat;
		end
	end

	assign result.valid       = valid_q;
	assign result.noise_value = noise_q;

endmodule

`default_nettype wire
